// ===== sv/lzwe_pkg.sv =====
// Shared constants, types and state codes for the LZW stream encoder.
package lzwe_pkg;

    localparam int CODE_BITS  = 12;
    localparam int BYTE_BITS  = 8;
    localparam int DICT_DEPTH = 1 << CODE_BITS;
    localparam int NODE_BITS  = 2 * CODE_BITS + BYTE_BITS;
    localparam int OUT_BITS   = ((CODE_BITS + 7) / 8) * 8;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [BYTE_BITS-1:0] byte_t;

    localparam code_t FIRST_PAIR = code_t'(1 << BYTE_BITS);
    localparam code_t FULL_COUNT = code_t'(DICT_DEPTH - 1);

    // Node record: sibling link, prefix code and byte of one pair code
    typedef struct packed {
        code_t sib;
        code_t prefix;
        byte_t data;
    } node_t;

    // One result handed from the sequencer to the output stage
    typedef struct packed {
        logic  valid;
        code_t code;
        logic  last;
    } emit_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_NODE,
        ST_MISS,
        ST_FINAL
    } state_t;

endpackage

// ===== sv/lzwe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lzwe_out_stage.sv =====
// Output register stage: holds one code until the receiver takes it.
module lzwe_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lzwe_pkg::emit_t             emit,
    output logic                        out_free,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lzwe_pkg::OUT_BITS-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    logic                valid_reg;
    lzwe_pkg::code_t     code_reg;
    logic                last_reg;

    assign out_free = !valid_reg || m_axis_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            code_reg <= emit.code;
            last_reg <= emit.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = lzwe_pkg::OUT_BITS'(code_reg);
    assign m_axis_tlast  = last_reg;

endmodule

// ===== sv/lzwe_ctrl.sv =====
// Sequencer: walks the child list of the prefix, inserts new pairs, emits codes.
module lzwe_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  lzwe_pkg::byte_t          in_byte,
    input  logic                     in_last,
    // head table: first child code of each prefix
    output logic                     head_we,
    output lzwe_pkg::code_t          head_waddr,
    output lzwe_pkg::code_t          head_wdata,
    output lzwe_pkg::code_t          head_raddr,
    input  lzwe_pkg::code_t          head_rdata,
    // node table: pair record of each code
    output logic                     node_we,
    output lzwe_pkg::code_t          node_waddr,
    output lzwe_pkg::node_t          node_wdata,
    output lzwe_pkg::code_t          node_raddr,
    input  lzwe_pkg::node_t          node_rdata,
    // output stage
    input  logic                     out_free,
    output lzwe_pkg::emit_t          emit
);

    lzwe_pkg::state_t state_reg, state_next;
    lzwe_pkg::code_t  prefix_reg, prefix_next;
    logic             held_reg, held_next;
    lzwe_pkg::code_t  nf_reg, nf_next;
    lzwe_pkg::code_t  clr_reg, clr_next;
    lzwe_pkg::byte_t  byte_reg, byte_next;
    logic             last_reg, last_next;
    lzwe_pkg::code_t  cand_reg, cand_next;
    lzwe_pkg::code_t  headv_reg, headv_next;
    logic             headok_reg, headok_next;

    logic                  accept;
    logic                  head_live;
    logic                  sib_live;
    logic [lzwe_pkg::CODE_BITS:0] nf_inc;

    assign accept    = in_valid && in_ready;
    assign head_live = (head_rdata >= lzwe_pkg::FIRST_PAIR) && (head_rdata < nf_reg);
    assign sib_live  = (node_rdata.sib >= lzwe_pkg::FIRST_PAIR) && (node_rdata.sib < nf_reg);
    assign nf_inc    = {1'b0, nf_reg} + 1'b1;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lzwe_pkg::ST_CLEAR;
            prefix_reg <= '0;
            held_reg   <= 1'b0;
            nf_reg     <= lzwe_pkg::FIRST_PAIR;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            held_reg   <= held_next;
            nf_reg     <= nf_next;
            clr_reg    <= clr_next;
        end
    end

    // working registers for the item in flight
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        cand_reg   <= cand_next;
        headv_reg  <= headv_next;
        headok_reg <= headok_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        held_next   = held_reg;
        nf_next     = nf_reg;
        clr_next    = clr_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        cand_next   = cand_reg;
        headv_next  = headv_reg;
        headok_next = headok_reg;
        in_ready    = 1'b0;
        head_we     = 1'b0;
        head_waddr  = prefix_reg;
        head_wdata  = nf_reg;
        head_raddr  = prefix_reg;
        node_we     = 1'b0;
        node_waddr  = nf_reg;
        node_wdata  = '{sib: (headok_reg ? headv_reg : '0), prefix: prefix_reg, data: byte_reg};
        node_raddr  = cand_reg;
        emit        = '{valid: 1'b0, code: prefix_reg, last: 1'b0};

        case (state_reg)
            // after reset: every head entry points below the pair codes
            lzwe_pkg::ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + lzwe_pkg::code_t'(1);
                if (clr_reg == lzwe_pkg::code_t'(lzwe_pkg::DICT_DEPTH - 1))
                begin
                    state_next = lzwe_pkg::ST_IDLE;
                end
            end

            lzwe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    byte_next = in_byte;
                    last_next = in_last;
                    if (!held_reg)
                    begin
                        prefix_next = lzwe_pkg::code_t'(in_byte);
                        held_next   = 1'b1;
                        state_next  = in_last ? lzwe_pkg::ST_FINAL : lzwe_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lzwe_pkg::ST_HEAD;
                    end
                end
            end

            // head entry for the prefix has arrived
            lzwe_pkg::ST_HEAD:
            begin
                headv_next  = head_rdata;
                headok_next = 1'b0;
                cand_next   = head_rdata;
                node_raddr  = head_rdata;
                state_next  = head_live ? lzwe_pkg::ST_NODE : lzwe_pkg::ST_MISS;
            end

            // compare one node of the child list
            lzwe_pkg::ST_NODE:
            begin
                if (node_rdata.prefix != prefix_reg)
                begin
                    // stale head from an earlier dictionary
                    state_next = lzwe_pkg::ST_MISS;
                end
                else
                begin
                    headok_next = 1'b1;
                    if (node_rdata.data == byte_reg)
                    begin
                        prefix_next = cand_reg;
                        state_next  = last_reg ? lzwe_pkg::ST_FINAL : lzwe_pkg::ST_IDLE;
                    end
                    else if (sib_live)
                    begin
                        cand_next  = node_rdata.sib;
                        node_raddr = node_rdata.sib;
                    end
                    else
                    begin
                        state_next = lzwe_pkg::ST_MISS;
                    end
                end
            end

            // emit prefix, insert the pair, restart from the byte
            lzwe_pkg::ST_MISS:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    node_we     = 1'b1;
                    head_we     = 1'b1;
                    prefix_next = lzwe_pkg::code_t'(byte_reg);
                    if (nf_inc >= {1'b0, lzwe_pkg::FULL_COUNT})
                    begin
                        nf_next = lzwe_pkg::FIRST_PAIR;
                    end
                    else
                    begin
                        nf_next = nf_inc[lzwe_pkg::CODE_BITS-1:0];
                    end
                    state_next = last_reg ? lzwe_pkg::ST_FINAL : lzwe_pkg::ST_IDLE;
                end
            end

            // flush the final prefix and restart the stream
            lzwe_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.last   = 1'b1;
                    nf_next     = lzwe_pkg::FIRST_PAIR;
                    prefix_next = '0;
                    held_next   = 1'b0;
                    state_next  = lzwe_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lzwe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lzw_stream_encoder_top.sv =====
// Top level of the LZW stream encoder: byte stream in, fixed-width codes out.
//
// Input channel s_axis: one byte per transfer in tdata, tlast marks the last
// byte of a stream. Output channel m_axis: one code per transfer in tdata,
// tlast set on the flushed final code of a stream.
// The dictionary is a tree kept in two RAMs: a head table (first child code
// of each prefix) and a node table (sibling link, prefix, byte per code).
// A byte that opens a stream only becomes the prefix. For each further byte the
// head entry of the prefix is read, then the child list is walked in the node
// table, one RAM read per node visited. A miss emits the prefix and inserts the
// pair; the final flush emits the last code. Dictionary entries are retired by
// resetting the next free code, so no pass over the tables is needed to clear them.
// After reset the head table is cleared with the input held off; the output
// register starts empty. When the receiver stalls, the finished code waits in
// the output register while the next byte is taken; the sequencer holds before
// its next emission until the register frees up.
module lzw_stream_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // data_byte
    input  logic                          s_axis_tlast,   // final_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzwe_pkg::OUT_BITS-1:0] m_axis_tdata,   // code_word, zero padded
    output logic                          m_axis_tlast    // stream_end
);

    logic            head_we;
    lzwe_pkg::code_t head_waddr, head_wdata, head_raddr, head_rdata;
    logic            node_we;
    lzwe_pkg::code_t node_waddr, node_raddr;
    lzwe_pkg::node_t node_wdata, node_rdata;
    logic            out_free;
    lzwe_pkg::emit_t emit;

    // first child of each prefix code
    lzwe_ram #(
        .WIDTH (lzwe_pkg::CODE_BITS),
        .DEPTH (lzwe_pkg::DICT_DEPTH)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    // pair record of each code
    lzwe_ram #(
        .WIDTH (lzwe_pkg::NODE_BITS),
        .DEPTH (lzwe_pkg::DICT_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    lzwe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .head_we    (head_we),
        .head_waddr (head_waddr),
        .head_wdata (head_wdata),
        .head_raddr (head_raddr),
        .head_rdata (head_rdata),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .out_free   (out_free),
        .emit       (emit)
    );

    lzwe_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (emit),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/lzwe_checker.sv =====
// Port-level checker for the LZW stream encoder, bound to the top level.
module lzwe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lzwe_pkg::OUT_BITS-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    // a stalled code stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");

    // a stalled code keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed under stall");

    // padding above the code is zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> lzwe_pkg::CODE_BITS) == '0)
        else $error("nonzero padding in output data");

    // a new code is loaded only while the input side is busy
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("code emitted while input side idle");

endmodule

bind lzw_stream_encoder_top lzwe_checker u_lzwe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
